FILE: rtl/slt_pkg.sv
// Package for the sorted list table: field widths, operation codes,
// the cell command code and the structs that pass between the top level and the cells.
// No dependencies.
`timescale 1ns / 1ps

package slt_pkg;

    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE_EVEN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY       = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_CAPTURE,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;
        logic signed [VALUE_W-1:0]  front;
        logic                       occupied;
        logic                       push;
    } cell_ctl_t;

    typedef struct packed {
        logic le;
        logic eq;
    } cell_sts_t;

endpackage

FILE: rtl/slt_ifs.sv
// Handshake interfaces for the request and response channels of the sorted list table.
// Depends on slt_pkg for the field widths.
`timescale 1ns / 1ps

interface slt_req_if;
    logic                               valid;
    logic                               ready;
    logic [slt_pkg::MODE_W-1:0]         mode;
    logic signed [slt_pkg::VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic [slt_pkg::COUNT_W-1:0]        count;
    logic                               is_empty;
    logic                               is_full;
    logic signed [slt_pkg::VALUE_W-1:0] largest;

    modport source (output valid, output ok, output count, output is_empty,
                    output is_full, output largest, input ready);
    modport sink   (input valid, input ok, input count, input is_empty,
                    input is_full, input largest, output ready);
endinterface

FILE: rtl/slt_cell.sv
// One slot of the sorted list table: holds an entry and trades it with its neighbors.
// Depends on slt_pkg for the cell command and status structs.
`timescale 1ns / 1ps

module slt_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  slt_pkg::cell_ctl_t                 ctl,
    input  logic                               left_le,
    input  logic signed [slt_pkg::VALUE_W-1:0] left_entry,
    input  logic signed [slt_pkg::VALUE_W-1:0] right_entry,
    output logic signed [slt_pkg::VALUE_W-1:0] entry,
    output slt_pkg::cell_sts_t                 sts
);

    logic signed [slt_pkg::VALUE_W-1:0] entry_reg;
    logic signed [slt_pkg::VALUE_W-1:0] entry_next;
    logic                               ge_reg;
    logic                               ge_next;
    logic                               eq_reg;
    logic                               eq_next;
    logic                               le_self;

    assign le_self = ctl.occupied && (entry_reg <= ctl.value);

    always_comb
    begin
        entry_next = entry_reg;
        ge_next    = ge_reg;
        eq_next    = eq_reg;
        case (ctl.op)
            slt_pkg::CELL_INSERT:
            begin
                // Entries at or below the new value stay; the first larger slot takes it.
                if (le_self)
                begin
                    entry_next = entry_reg;
                end
                else if (left_le)
                begin
                    entry_next = ctl.value;
                end
                else
                begin
                    entry_next = left_entry;
                end
            end
            slt_pkg::CELL_CAPTURE:
            begin
                ge_next = ctl.occupied && (entry_reg >= ctl.value);
                eq_next = ctl.occupied && (entry_reg == ctl.value);
            end
            slt_pkg::CELL_SHIFT:
            begin
                if (ge_reg)
                begin
                    entry_next = right_entry;
                end
            end
            slt_pkg::CELL_ROTATE:
            begin
                entry_next = ctl.push ? ctl.front : right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            ge_reg <= ge_next;
            eq_reg <= eq_next;
        end
    end

    assign entry  = entry_reg;
    assign sts.le = le_self;
    assign sts.eq = eq_reg;

endmodule

FILE: rtl/sorted_list_table.sv
// Top level of the sorted list table: control sequencer, chain of slt_cell slots and
// the registered response stage. Depends on slt_pkg, slt_ifs and slt_cell.
`timescale 1ns / 1ps

// Channel  Direction  Fields                                   Transaction when
// -------  ---------  ---------------------------------------  ----------------------
// req      in         mode[1:0], value[31:0] signed            req.valid && req.ready
// rsp      out        ok, count[4:0], is_empty, is_full,       rsp.valid && rsp.ready
//                     largest[31:0] signed
//
// Sequence: query and insert go from idle straight to the finish state, remove of a
// value passes through S_RMV for the shift, and remove of all even entries rotates
// the cell chain by one slot per cycle in S_EVEN, once per held entry.
// Reset: rst_n clears the entry count, the sequencer and the response valid; the slot
// contents are not cleared because no slot at or above the count reaches a response.
// Stalls: a response waiting on rsp.ready does not block a new request; the next
// result waits in the finish state until the response register frees up.
module sorted_list_table #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    slt_req_if.sink        req,
    slt_rsp_if.source      rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // The sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RMV  = 4'b0010,
        S_EVEN = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic [CW-1:0] held_reg;
    logic [CW-1:0] held_next;
    logic [CW-1:0] steps_reg;
    logic [CW-1:0] steps_next;
    logic [CW-1:0] orig_reg;
    logic [CW-1:0] orig_next;
    logic          ok_reg;
    logic          ok_next;

    logic                               rsp_valid_reg;
    logic                               rsp_ok_reg;
    logic [slt_pkg::COUNT_W-1:0]        rsp_count_reg;
    logic                               rsp_empty_reg;
    logic                               rsp_full_reg;
    logic signed [slt_pkg::VALUE_W-1:0] rsp_largest_reg;

    slt_pkg::cell_op_t                  cell_op;
    logic                               push_en;
    logic                               load_out;
    logic                               any_match;
    logic [CW-1:0]                      last_idx;
    logic [CW+slt_pkg::COUNT_W-1:0]     count_wide;
    logic signed [slt_pkg::VALUE_W-1:0] largest_sel;

    slt_pkg::cell_ctl_t                 ctl [DEPTH];
    slt_pkg::cell_sts_t                 sts [DEPTH];
    logic signed [slt_pkg::VALUE_W-1:0] entry [DEPTH];
    logic [DEPTH-1:0]                   eq_vec;
    logic [DEPTH-1:0]                   last_sel;

    assign last_idx = CW'(held_reg - 1'b1);

    // Per-slot commands: occupancy, the push target of the rotation and the last slot.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctl[i].op       = cell_op;
            ctl[i].value    = req.value;
            ctl[i].front    = entry[0];
            ctl[i].occupied = held_reg > CW'(i);
            ctl[i].push     = push_en && (CW'(i) == last_idx);
            last_sel[i]     = (held_reg > CW'(i)) && (CW'(i) == last_idx);
            eq_vec[i]       = sts[i].eq;
        end
    end

    // The chain of slots. The first slot always sees an open place on its left, and
    // the last slot has no right neighbor, so it reads itself.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic                               left_le;
        logic signed [slt_pkg::VALUE_W-1:0] left_entry;
        logic signed [slt_pkg::VALUE_W-1:0] right_entry;

        if (g == 0)
        begin : g_first
            assign left_le    = 1'b1;
            assign left_entry = entry[0];
        end
        else
        begin : g_inner
            assign left_le    = sts[g-1].le;
            assign left_entry = entry[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_entry = entry[g];
        end
        else
        begin : g_body
            assign right_entry = entry[g+1];
        end

        slt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl[g]),
            .left_le     (left_le),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry[g]),
            .sts         (sts[g])
        );
    end

    // A remove only goes ahead when some held slot matched in the capture cycle.
    assign any_match = |eq_vec;

    // Sequencer. Remove of even entries pops the front slot once per held entry and
    // pushes it back behind the kept entries when it is odd, so the odd entries come
    // out in their original order.
    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        steps_next = steps_reg;
        orig_next  = orig_reg;
        ok_next    = ok_reg;
        cell_op    = slt_pkg::CELL_HOLD;
        push_en    = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.mode)
                        slt_pkg::MODE_INSERT:
                        begin
                            if (held_reg != DEPTH_C)
                            begin
                                cell_op   = slt_pkg::CELL_INSERT;
                                held_next = CW'(held_reg + 1'b1);
                                ok_next   = 1'b1;
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                            state_next = S_FIN;
                        end
                        slt_pkg::MODE_REMOVE:
                        begin
                            cell_op    = slt_pkg::CELL_CAPTURE;
                            state_next = S_RMV;
                        end
                        slt_pkg::MODE_REMOVE_EVEN:
                        begin
                            if (held_reg == '0)
                            begin
                                ok_next    = 1'b0;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                steps_next = held_reg;
                                orig_next  = held_reg;
                                state_next = S_EVEN;
                            end
                        end
                        default:
                        begin
                            ok_next    = 1'b1;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_RMV:
            begin
                if (any_match)
                begin
                    cell_op   = slt_pkg::CELL_SHIFT;
                    held_next = CW'(held_reg - 1'b1);
                end
                ok_next    = any_match;
                state_next = S_FIN;
            end
            S_EVEN:
            begin
                cell_op = slt_pkg::CELL_ROTATE;
                push_en = entry[0][0];
                if (!push_en)
                begin
                    held_next = CW'(held_reg - 1'b1);
                end
                steps_next = CW'(steps_reg - 1'b1);
                if (steps_reg == CW'(1))
                begin
                    ok_next    = held_next != orig_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The greatest entry is the last held slot, picked by a one-hot select.
    always_comb
    begin
        largest_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            largest_sel = largest_sel | ({slt_pkg::VALUE_W{last_sel[i]}} & entry[i]);
        end
    end

    // The count field is the held count taken modulo 32.
    assign count_wide = {{slt_pkg::COUNT_W{1'b0}}, held_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            steps_reg     <= '0;
            orig_reg      <= '0;
            ok_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            steps_reg <= steps_next;
            orig_reg  <= orig_next;
            ok_reg    <= ok_next;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_ok_reg      <= ok_reg;
            rsp_count_reg   <= count_wide[slt_pkg::COUNT_W-1:0];
            rsp_empty_reg   <= held_reg == '0;
            rsp_full_reg    <= held_reg == DEPTH_C;
            rsp_largest_reg <= largest_sel;
        end
    end

    assign req.ready    = state_reg == S_IDLE;
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.ok       = rsp_ok_reg;
    assign rsp.count    = rsp_count_reg;
    assign rsp.is_empty = rsp_empty_reg;
    assign rsp.is_full  = rsp_full_reg;
    assign rsp.largest  = rsp_largest_reg;

    // The entry count never goes past the table depth.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= DEPTH_C)
        else $error("entry count above table depth");

    // An insert into a table that is not full adds exactly one entry.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req.valid && req.mode == slt_pkg::MODE_INSERT
         && held_reg != DEPTH_C)
        |=> held_reg == CW'($past(held_reg) + 1'b1))
        else $error("insert did not add one entry");

    // The rotation never runs with its step counter exhausted.
    a_even_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVEN |-> steps_reg != '0)
        else $error("even removal ran past its last step");

    // A response only appears out of the finish state.
    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("response raised outside the finish state");

    // A full table is never reported as empty.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.is_full |-> !rsp.is_empty)
        else $error("response both full and empty");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for sorted_list_table: directed and random request traffic
// checked against a behavioral model of the ordered table kept inside the bench.
// Depends on slt_pkg, slt_ifs and the sorted_list_table RTL.
`timescale 1ns / 1ps

module tb_top;
    import slt_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    // Cycles without any transaction on either channel before the run is abandoned.
    // The slowest operation is an even removal on a full table, so this leaves a wide
    // margin even under a long run of receiver stalls.
    localparam int STALL_LIMIT   = 5000;
    // Quiet cycles after the last response, so that a stray extra response is caught.
    localparam int SETTLE_CYCLES = 40;
    // Chance in percent that a side idles in a given cycle.
    localparam int IDLE_PCT      = 24;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // What the block is expected to report after one operation.
    typedef struct packed {
        logic                      ok;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic                      is_full;
        logic signed [VALUE_W-1:0] largest;
    } table_status_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    slt_req_if req_if ();
    slt_rsp_if rsp_if ();

    sorted_list_table #(
        .DEPTH (TABLE_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // The bench's own copy of the table, kept in ascending order, and the statuses
    // still owed by the block, oldest first.
    logic signed [VALUE_W-1:0] table_entries[$];
    table_status_t             pending_status[$];

    int error_count  = 0;
    int stall_cycles = 0;
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;

    // Applies one operation to the bench's table and returns the status the block
    // must report for it. Failed operations leave the table untouched.
    function automatic table_status_t apply_table_op(input logic [MODE_W-1:0] mode,
                                                     input logic signed [VALUE_W-1:0] value);
        table_status_t             st;
        int                        pos;
        logic signed [VALUE_W-1:0] odd_entries[$];

        st.ok = 1'b1;
        case (mode)
            MODE_INSERT:
            begin
                if (table_entries.size() >= TABLE_DEPTH)
                begin
                    st.ok = 1'b0;
                end
                else
                begin
                    // New value goes after every entry that is less than or equal to it.
                    pos = 0;
                    while (pos < table_entries.size() && table_entries[pos] <= value)
                        pos++;
                    table_entries.insert(pos, value);
                end
            end
            MODE_REMOVE:
            begin
                pos = 0;
                while (pos < table_entries.size() && table_entries[pos] != value)
                    pos++;
                if (pos >= table_entries.size())
                    st.ok = 1'b0;
                else
                    table_entries.delete(pos);
            end
            MODE_REMOVE_EVEN:
            begin
                foreach (table_entries[i])
                    if (table_entries[i][0])
                        odd_entries.push_back(table_entries[i]);
                // Nothing even to remove, which includes the empty table, is a failure.
                if (odd_entries.size() == table_entries.size())
                    st.ok = 1'b0;
                else
                    table_entries = odd_entries;
            end
            default:
            begin
                st.ok = 1'b1;
            end
        endcase

        st.count    = COUNT_W'(table_entries.size());
        st.is_empty = (table_entries.size() == 0);
        st.is_full  = (table_entries.size() == TABLE_DEPTH);
        st.largest  = (table_entries.size() > 0) ? table_entries[$] : '0;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    // Sends one request transaction. Before it, the sender may idle with valid low.
    // Valid stays high afterwards, so a following call with no idle cycles presents
    // its transaction back to back.
    task automatic send_op(input logic [MODE_W-1:0] mode,
                           input logic signed [VALUE_W-1:0] value);
        while (send_idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.value <= value;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_status.push_back(apply_table_op(mode, value));
    endtask

    // Drops valid and holds off until every owed response has arrived.
    task automatic wait_for_responses();
        req_if.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    // Random value: in about a third of draws a narrow band around zero so that duplicates and hits on
    // removal are common, some extremes, and the rest spread over the whole word.
    function automatic logic signed [VALUE_W-1:0] random_value();
        logic signed [VALUE_W-1:0] v;
        int                        r;

        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            v = $urandom_range(0, 16);
            v = v - 8;
        end
        else if (r < 45)
        begin
            case ($urandom_range(0, 5))
                0:       v = VALUE_MIN;
                1:       v = VALUE_MIN + 1;
                2:       v = VALUE_MAX;
                3:       v = VALUE_MAX - 1;
                4:       v = '0;
                default: v = -1;
            endcase
        end
        else
        begin
            v = $urandom();
        end
        return v;
    endfunction

    // A growing phase favors inserts and a shrinking phase favors removals, so the
    // table swings between empty and full many times.
    function automatic logic [MODE_W-1:0] pick_mode(input bit growing);
        int r;

        r = $urandom_range(0, 99);
        if (growing)
        begin
            if (r < 58)      return MODE_INSERT;
            else if (r < 80) return MODE_REMOVE;
            else if (r < 88) return MODE_REMOVE_EVEN;
            else             return MODE_QUERY;
        end
        else
        begin
            if (r < 25)      return MODE_INSERT;
            else if (r < 75) return MODE_REMOVE;
            else if (r < 88) return MODE_REMOVE_EVEN;
            else             return MODE_QUERY;
        end
    endfunction

    // Query, removal and even removal on an empty table.
    task automatic test_empty_table();
        send_op(MODE_QUERY, '0);
        send_op(MODE_REMOVE, 32'sd5);
        send_op(MODE_REMOVE_EVEN, -32'sd1);
    endtask

    // Extreme values, negative even and odd words, duplicates and failed removals.
    task automatic test_extreme_values();
        send_op(MODE_INSERT, VALUE_MIN);
        send_op(MODE_INSERT, VALUE_MAX);
        send_op(MODE_INSERT, '0);
        send_op(MODE_INSERT, -32'sd1);
        send_op(MODE_INSERT, -32'sd2);
        send_op(MODE_INSERT, 32'sd7);
        send_op(MODE_INSERT, 32'sd7);
        // Drops the minimum, -2 and 0, leaving only odd words behind.
        send_op(MODE_REMOVE_EVEN, '0);
        send_op(MODE_REMOVE_EVEN, '0);
        send_op(MODE_REMOVE, 32'sd3);
        send_op(MODE_REMOVE, VALUE_MAX);
    endtask

    // Fills the table, then tries an insert, an absent removal and a query while it is full.
    task automatic test_full_table();
        while (table_entries.size() < TABLE_DEPTH)
            send_op(MODE_INSERT, random_value());
        send_op(MODE_INSERT, 32'sd1);
        send_op(MODE_REMOVE, 32'sd123457);
        send_op(MODE_QUERY, '0);
    endtask

    task automatic test_random_traffic(input int n_items);
        bit                        growing;
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;

        growing = 1'b1;
        for (int k = 0; k < n_items; k++)
        begin
            if (table_entries.size() == TABLE_DEPTH)
                growing = 1'b0;
            else if (table_entries.size() == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                growing = !growing;

            mode  = pick_mode(growing);
            value = random_value();
            // Most removals name a value that is actually held, so that the shift
            // down from every slot position gets exercised.
            if (mode == MODE_REMOVE && table_entries.size() > 0 && $urandom_range(0, 99) < 70)
                value = table_entries[$urandom_range(0, table_entries.size() - 1)];
            send_op(mode, value);
        end
    endtask

    // Bursts of traffic, each followed by a full pause until the block has answered
    // everything, so that the block is seen going idle with the table in many states.
    task automatic test_drain_pause();
        for (int b = 0; b < 4; b++)
        begin
            test_random_traffic(50);
            wait_for_responses();
        end
    endtask

    // Back-to-back traffic on both sides with no idle cycles at all.
    task automatic test_no_idle_stretch();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        test_random_traffic(400);
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    // Response checker. Every response transaction is compared field by field with
    // the oldest owed status. The receiver's ready is redrawn every cycle.
    always @(posedge clk)
    begin
        table_status_t want;

        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_status.size() == 0)
            begin
                report_mismatch("response with nothing owed, count", rsp_if.count, 0);
            end
            else
            begin
                want = pending_status.pop_front();
                if (rsp_if.ok !== want.ok)
                    report_mismatch("ok", rsp_if.ok, want.ok);
                if (rsp_if.count !== want.count)
                    report_mismatch("count", rsp_if.count, want.count);
                if (rsp_if.is_empty !== want.is_empty)
                    report_mismatch("is_empty", rsp_if.is_empty, want.is_empty);
                if (rsp_if.is_full !== want.is_full)
                    report_mismatch("is_full", rsp_if.is_full, want.is_full);
                if (rsp_if.largest !== want.largest)
                    report_mismatch("largest", rsp_if.largest, want.largest);
            end
        end
        rsp_if.ready <= !(recv_idle_en && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: a long run of cycles with no transaction on either channel means the
    // block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        req_if.valid <= 1'b0;
        req_if.mode  <= MODE_QUERY;
        req_if.value <= '0;

        // Reset is held low from the start and released on a rising edge.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_extreme_values();
        test_full_table();
        test_random_traffic(700);
        test_drain_pause();
        test_no_idle_stretch();
        test_random_traffic(300);

        // All stimulus is in; wait for the last responses, then stay quiet long enough
        // to catch anything the block sends on its own.
        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/slt_pkg.sv
rtl/slt_ifs.sv
rtl/slt_cell.sv
rtl/sorted_list_table.sv
sim/tb_top.sv
